FILE: hw/rtl/fsdc_pkg.sv
// shared types and opcode constants for the flux stream decoder and checker
package fsdc_pkg;

  // stream opcodes
  localparam logic [7:0] OP_FLUX2_MAX = 8'h07;
  localparam logic [7:0] OP_NOP1      = 8'h08;
  localparam logic [7:0] OP_NOP2      = 8'h09;
  localparam logic [7:0] OP_NOP3      = 8'h0A;
  localparam logic [7:0] OP_OVERFLOW  = 8'h0B;
  localparam logic [7:0] OP_FLUX3     = 8'h0C;
  localparam logic [7:0] OP_OOB       = 8'h0D;
  localparam logic [7:0] OP_FLUX1_MIN = 8'h0E;

  // out-of-band block types
  localparam logic [7:0] BLK_INFO  = 8'h01;
  localparam logic [7:0] BLK_INDEX = 8'h02;
  localparam logic [7:0] BLK_END   = 8'h03;
  localparam logic [7:0] BLK_EOF   = 8'h0D;

  localparam logic [31:0] OVERFLOW_STEP    = 32'h0001_0000;
  localparam logic [19:0] FLUX_LIMIT_RESET = 20'd500000;
  localparam int          POS_BYTES        = 4;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_F2_LO     = 4'd1,
    PH_F3_HI     = 4'd2,
    PH_F3_LO     = 4'd3,
    PH_SKIP      = 4'd4,
    PH_OOB_TYPE  = 4'd5,
    PH_OOB_SZ_LO = 4'd6,
    PH_OOB_SZ_HI = 4'd7,
    PH_OOB_DATA  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FLUX    = 2'd0,
    KIND_CHECK   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] flux_ticks;
    logic [31:0] position_counted;
    logic [31:0] position_reported;
    logic        position_ok;
    logic [31:0] flux_total;
    logic [31:0] block_total;
    logic [31:0] index_total;
    logic [31:0] overflow_total;
    logic        all_positions_ok;
    logic        truncated;
    logic        last_of_run;
  } result_t;

  // up to two results per request, first then second
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

endpackage

FILE: hw/rtl/fsdc_parser.sv
// input register, opcode decode and per-stream state of the flux stream checker
module fsdc_parser
  import fsdc_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_buffer,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  input  logic        room,
  output push_t       push
);

  localparam int CW = COUNTER_WIDTH;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  logic        hold_valid_r;
  logic [7:0]  hold_byte_r;
  logic        hold_eob_r;
  logic        fire;

  logic [19:0] flux_limit_r;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  skip_r, skip_nxt;
  logic [7:0]  btype_r, btype_nxt;
  logic [15:0] bleft_r, bleft_nxt;
  logic [2:0]  pidx_r, pidx_nxt;
  logic [31:0] ppos_r, ppos_nxt;
  logic [31:0] bpos_r, bpos_nxt;
  logic [31:0] ovsum_r, ovsum_nxt;
  logic [7:0]  vhigh_r, vhigh_nxt;
  logic [CW-1:0] flux_cnt_r, flux_cnt_nxt;
  logic [CW-1:0] blk_cnt_r, blk_cnt_nxt;
  logic [CW-1:0] idx_cnt_r, idx_cnt_nxt;
  logic [CW-1:0] ovf_cnt_r, ovf_cnt_nxt;
  logic        mism_r, mism_nxt;
  logic        ended_r, ended_nxt;

  logic        do_flux, do_finish, pos_inc;
  logic [15:0] flux_val;
  logic [32:0] tick_sum;
  logic [32:0] ovf_sum;
  logic [1:0]  skip_dec;
  logic [15:0] bleft_dec;
  logic [15:0] size_word;
  logic        first_valid;
  result_t     first_res, summary_res;
  logic        pos_ok;

  assign fire     = hold_valid_r && room;
  assign in_ready = !hold_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_byte_r <= in_stream_byte;
      hold_eob_r  <= in_end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flux_limit_r <= FLUX_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      flux_limit_r <= cfg_wr_data;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    btype_nxt    = btype_r;
    bleft_nxt    = bleft_r;
    pidx_nxt     = pidx_r;
    ppos_nxt     = ppos_r;
    bpos_nxt     = bpos_r;
    ovsum_nxt    = ovsum_r;
    vhigh_nxt    = vhigh_r;
    flux_cnt_nxt = flux_cnt_r;
    blk_cnt_nxt  = blk_cnt_r;
    idx_cnt_nxt  = idx_cnt_r;
    ovf_cnt_nxt  = ovf_cnt_r;
    mism_nxt     = mism_r;
    ended_nxt    = ended_r;
    do_flux      = 1'b0;
    do_finish    = 1'b0;
    pos_inc      = 1'b0;
    flux_val     = 16'd0;
    tick_sum     = 33'd0;
    ovf_sum      = {1'b0, ovsum_r} + {1'b0, OVERFLOW_STEP};
    skip_dec     = skip_r - {1'b0, skip_r != 2'd0};
    bleft_dec    = bleft_r - {15'd0, bleft_r != 16'd0};
    size_word    = {hold_byte_r, bleft_r[7:0]};
    first_valid  = 1'b0;
    pos_ok       = 1'b0;
    first_res    = '0;
    summary_res  = '0;

    if (!ended_r) begin
      case (phase_r)
        PH_IDLE: begin
          if (hold_byte_r == OP_OOB) begin
            phase_nxt = PH_OOB_TYPE;
            pidx_nxt  = 3'd0;
            ppos_nxt  = 32'd0;
          end else begin
            pos_inc = 1'b1;
            if (hold_byte_r >= OP_FLUX1_MIN) begin
              do_flux  = 1'b1;
              flux_val = {8'd0, hold_byte_r};
            end else if (hold_byte_r <= OP_FLUX2_MAX) begin
              vhigh_nxt = hold_byte_r;
              phase_nxt = PH_F2_LO;
            end else if (hold_byte_r == OP_OVERFLOW) begin
              ovsum_nxt   = ovf_sum[32] ? 32'hFFFF_FFFF : ovf_sum[31:0];
              ovf_cnt_nxt = sat_inc(ovf_cnt_r);
            end else if (hold_byte_r == OP_FLUX3) begin
              phase_nxt = PH_F3_HI;
            end else if (hold_byte_r == OP_NOP2 || hold_byte_r == OP_NOP3) begin
              skip_nxt  = 2'(hold_byte_r - OP_NOP1);
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_F2_LO, PH_F3_LO: begin
          pos_inc  = 1'b1;
          do_flux  = 1'b1;
          flux_val = {vhigh_r, hold_byte_r};
        end
        PH_F3_HI: begin
          pos_inc   = 1'b1;
          vhigh_nxt = hold_byte_r;
          phase_nxt = PH_F3_LO;
        end
        PH_SKIP: begin
          pos_inc  = 1'b1;
          skip_nxt = skip_dec;
          if (skip_dec == 2'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_OOB_TYPE: begin
          btype_nxt = hold_byte_r;
          phase_nxt = PH_OOB_SZ_LO;
        end
        PH_OOB_SZ_LO: begin
          bleft_nxt = {8'd0, hold_byte_r};
          phase_nxt = PH_OOB_SZ_HI;
        end
        PH_OOB_SZ_HI: begin
          bleft_nxt = size_word;
          if (btype_r == BLK_EOF) begin
            ended_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (size_word == 16'd0) begin
            do_finish = 1'b1;
          end else begin
            phase_nxt = PH_OOB_DATA;
          end
        end
        PH_OOB_DATA: begin
          if (pidx_r < 3'(POS_BYTES)) begin
            ppos_nxt = ppos_r | ({24'd0, hold_byte_r} << {pidx_r[1:0], 3'b000});
            pidx_nxt = pidx_r + 3'd1;
          end
          bleft_nxt = bleft_dec;
          if (bleft_dec == 16'd0) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (pos_inc) begin
      bpos_nxt = bpos_r + 32'd1;
    end

    if (do_flux) begin
      tick_sum     = {1'b0, ovsum_r} + {17'd0, flux_val};
      first_valid  = 32'(flux_cnt_r) < {12'd0, flux_limit_r};
      ovsum_nxt    = 32'd0;
      flux_cnt_nxt = sat_inc(flux_cnt_r);
      phase_nxt    = PH_IDLE;
      first_res.kind       = KIND_FLUX;
      first_res.flux_ticks = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
    end

    if (do_finish) begin
      pos_ok = ppos_nxt == bpos_nxt;
      if ((btype_r == BLK_INFO || btype_r == BLK_INDEX || btype_r == BLK_END) &&
          pidx_nxt >= 3'(POS_BYTES)) begin
        first_valid = 1'b1;
        if (!pos_ok) begin
          mism_nxt = 1'b1;
        end
      end
      first_res.kind              = KIND_CHECK;
      first_res.position_counted  = bpos_nxt;
      first_res.position_reported = ppos_nxt;
      first_res.position_ok       = pos_ok;
      blk_cnt_nxt = sat_inc(blk_cnt_r);
      if (btype_r == BLK_INDEX) begin
        idx_cnt_nxt = sat_inc(idx_cnt_r);
      end
      phase_nxt = PH_IDLE;
      pidx_nxt  = 3'd0;
      ppos_nxt  = 32'd0;
    end

    // totals reflect this byte, taken before the end-of-buffer clear
    first_res.flux_total       = 32'(flux_cnt_nxt);
    first_res.block_total      = 32'(blk_cnt_nxt);
    first_res.index_total      = 32'(idx_cnt_nxt);
    first_res.overflow_total   = 32'(ovf_cnt_nxt);
    first_res.all_positions_ok = !mism_nxt;
    first_res.last_of_run      = !hold_eob_r;

    summary_res.kind             = KIND_SUMMARY;
    summary_res.flux_total       = 32'(flux_cnt_nxt);
    summary_res.block_total      = 32'(blk_cnt_nxt);
    summary_res.index_total      = 32'(idx_cnt_nxt);
    summary_res.overflow_total   = 32'(ovf_cnt_nxt);
    summary_res.all_positions_ok = !mism_nxt;
    summary_res.truncated        = !ended_nxt && (phase_nxt != PH_IDLE);
    summary_res.last_of_run      = 1'b1;

    push.first_valid  = fire && (first_valid || hold_eob_r);
    push.second_valid = fire && first_valid && hold_eob_r;
    push.first        = first_valid ? first_res : summary_res;
    push.second       = summary_res;

    if (hold_eob_r) begin
      phase_nxt    = PH_IDLE;
      skip_nxt     = 2'd0;
      btype_nxt    = 8'd0;
      bleft_nxt    = 16'd0;
      pidx_nxt     = 3'd0;
      ppos_nxt     = 32'd0;
      bpos_nxt     = 32'd0;
      ovsum_nxt    = 32'd0;
      vhigh_nxt    = 8'd0;
      flux_cnt_nxt = '0;
      blk_cnt_nxt  = '0;
      idx_cnt_nxt  = '0;
      ovf_cnt_nxt  = '0;
      mism_nxt     = 1'b0;
      ended_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      skip_r     <= 2'd0;
      btype_r    <= 8'd0;
      bleft_r    <= 16'd0;
      pidx_r     <= 3'd0;
      ppos_r     <= 32'd0;
      bpos_r     <= 32'd0;
      ovsum_r    <= 32'd0;
      vhigh_r    <= 8'd0;
      flux_cnt_r <= '0;
      blk_cnt_r  <= '0;
      idx_cnt_r  <= '0;
      ovf_cnt_r  <= '0;
      mism_r     <= 1'b0;
      ended_r    <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      btype_r    <= btype_nxt;
      bleft_r    <= bleft_nxt;
      pidx_r     <= pidx_nxt;
      ppos_r     <= ppos_nxt;
      bpos_r     <= bpos_nxt;
      ovsum_r    <= ovsum_nxt;
      vhigh_r    <= vhigh_nxt;
      flux_cnt_r <= flux_cnt_nxt;
      blk_cnt_r  <= blk_cnt_nxt;
      idx_cnt_r  <= idx_cnt_nxt;
      ovf_cnt_r  <= ovf_cnt_nxt;
      mism_r     <= mism_nxt;
      ended_r    <= ended_nxt;
    end
  end

endmodule

FILE: hw/rtl/fsdc_result_fifo.sv
// small result queue taking up to two results a cycle and giving one
module fsdc_result_fifo
  import fsdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t              mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic [RES_PTR_W-1:0] wr_ptr_2nd;
  logic                 pop;

  assign out_valid  = count_r != '0;
  assign pop        = out_valid && out_ready;
  assign head       = mem_r[rd_ptr_r];
  // room for a request that may bring two results
  assign room       = count_r <= RES_CNT_W'(RES_DEPTH - 2);
  assign wr_ptr_2nd = wr_ptr_r + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.first_valid) + RES_PTR_W'(push.second_valid);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push.first_valid) + RES_CNT_W'(push.second_valid)
                 - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.second_valid) begin
      mem_r[wr_ptr_2nd] <= push.second;
    end
  end

endmodule

FILE: hw/rtl/flux_stream_decoder_checker.sv
// top level of the flux stream decoder and checker
//
//   port group   direction  handshake              content
//   in_*         input      in_valid / in_ready    one stream byte and end-of-buffer flag
//   out_*        output     out_valid / out_ready  flux interval, position check or summary
//   cfg_*        input      cfg_wr_en              flux_limit, 20 bits
//
// one byte is taken per cycle, while the result queue has room, through an input register;
// decode and state update finish in the cycle the byte leaves that register
// a byte yields zero, one or two results; the 4-entry result queue accepts a byte only
// with two free entries, so out_ready low stalls the input once results fill the queue
// rst_n is synchronous: parse state and totals clear and flux_limit returns to 500000

module flux_stream_decoder_checker
  import fsdc_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_flux_ticks,
  output logic [31:0] out_position_counted,
  output logic [31:0] out_position_reported,
  output logic        out_position_ok,
  output logic [31:0] out_flux_total,
  output logic [31:0] out_block_total,
  output logic [31:0] out_index_total,
  output logic [31:0] out_overflow_total,
  output logic        out_all_positions_ok,
  output logic        out_truncated,
  output logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data
);

  push_t   push;
  logic    room;
  result_t head;

  fsdc_parser #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_stream_byte  (in_stream_byte),
    .in_end_of_buffer(in_end_of_buffer),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .room            (room),
    .push            (push)
  );

  fsdc_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_kind              = head.kind;
  assign out_flux_ticks        = head.flux_ticks;
  assign out_position_counted  = head.position_counted;
  assign out_position_reported = head.position_reported;
  assign out_position_ok       = head.position_ok;
  assign out_flux_total        = head.flux_total;
  assign out_block_total       = head.block_total;
  assign out_index_total       = head.index_total;
  assign out_overflow_total    = head.overflow_total;
  assign out_all_positions_ok  = head.all_positions_ok;
  assign out_truncated         = head.truncated;
  assign out_last_of_run       = head.last_of_run;

endmodule

FILE: verif/flux_result_checker.sv
// scoreboard for the flux stream decoder: predicts every result from the accepted bytes
module flux_result_checker
  import fsdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_buffer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_flux_ticks,
  input  logic [31:0] out_position_counted,
  input  logic [31:0] out_position_reported,
  input  logic        out_position_ok,
  input  logic [31:0] out_flux_total,
  input  logic [31:0] out_block_total,
  input  logic [31:0] out_index_total,
  input  logic [31:0] out_overflow_total,
  input  logic        out_all_positions_ok,
  input  logic        out_truncated,
  input  logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  output int          mismatches,
  output int          records_due
);

  localparam logic [31:0] TOTAL_MAX   = 32'hFFFF_FFFF;
  localparam int          MAX_REPORTS = 200;

  result_t     awaited_records[$];
  logic [19:0] flux_cap;

  // decoder state as the block should hold it
  phase_t      ph;
  logic [1:0]  nop_left;
  logic [7:0]  oob_type;
  logic [7:0]  hi_byte;
  logic [15:0] oob_left;
  logic [2:0]  pay_idx;
  logic [31:0] pay_pos;
  logic [31:0] byte_pos;
  logic [31:0] ovf_acc;
  logic [31:0] n_flux;
  logic [31:0] n_block;
  logic [31:0] n_index;
  logic [31:0] n_ovf;
  logic        bad_pos;
  logic        eof_seen;
  int          error_n = 0;

  function automatic logic [31:0] count_up(input logic [31:0] x);
    return (x == TOTAL_MAX) ? x : x + 32'd1;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TOTAL_MAX : s[31:0];
  endfunction

  function automatic void clear_stream();
    ph       = PH_IDLE;
    nop_left = '0;
    oob_type = '0;
    hi_byte  = '0;
    oob_left = '0;
    pay_idx  = '0;
    pay_pos  = '0;
    byte_pos = '0;
    ovf_acc  = '0;
    n_flux   = '0;
    n_block  = '0;
    n_index  = '0;
    n_ovf    = '0;
    bad_pos  = 1'b0;
    eof_seen = 1'b0;
  endfunction

  // every record carries the running totals after the byte
  function automatic result_t totals_record(input kind_t k);
    result_t r;
    r                  = '0;
    r.kind             = k;
    r.flux_total       = n_flux;
    r.block_total      = n_block;
    r.index_total      = n_index;
    r.overflow_total   = n_ovf;
    r.all_positions_ok = !bad_pos;
    return r;
  endfunction

  function automatic void emit_interval(input logic [31:0] val);
    result_t     r;
    logic [31:0] ticks;
    logic        shown;
    ticks   = add_sat(ovf_acc, val);
    shown   = n_flux < {12'd0, flux_cap};
    ovf_acc = '0;
    n_flux  = count_up(n_flux);
    ph      = PH_IDLE;
    if (shown) begin
      r            = totals_record(KIND_FLUX);
      r.flux_ticks = ticks;
      awaited_records.push_back(r);
    end
  endfunction

  function automatic void close_block();
    result_t r;
    logic    ok;
    ok      = (pay_pos == byte_pos);
    n_block = count_up(n_block);
    if (oob_type == BLK_INDEX)
      n_index = count_up(n_index);
    if ((oob_type == BLK_INFO || oob_type == BLK_INDEX || oob_type == BLK_END) &&
        pay_idx >= POS_BYTES) begin
      if (!ok)
        bad_pos = 1'b1;
      r                   = totals_record(KIND_CHECK);
      r.position_counted  = byte_pos;
      r.position_reported = pay_pos;
      r.position_ok       = ok;
      awaited_records.push_back(r);
    end
    ph      = PH_IDLE;
    pay_idx = '0;
    pay_pos = '0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eob);
    result_t r;
    int      due_before;
    due_before = awaited_records.size();
    if (!eof_seen) begin
      case (ph)
        PH_IDLE: begin
          if (b == OP_OOB) begin
            ph      = PH_OOB_TYPE;
            pay_idx = '0;
            pay_pos = '0;
          end else begin
            byte_pos = byte_pos + 32'd1;
            if (b >= OP_FLUX1_MIN) begin
              emit_interval({24'd0, b});
            end else if (b <= OP_FLUX2_MAX) begin
              hi_byte = b;
              ph      = PH_F2_LO;
            end else if (b == OP_OVERFLOW) begin
              ovf_acc = add_sat(ovf_acc, OVERFLOW_STEP);
              n_ovf   = count_up(n_ovf);
            end else if (b == OP_FLUX3) begin
              ph = PH_F3_HI;
            end else if (b == OP_NOP2 || b == OP_NOP3) begin
              nop_left = 2'(b - OP_NOP1);
              ph       = PH_SKIP;
            end
          end
        end
        PH_F2_LO, PH_F3_LO: begin
          byte_pos = byte_pos + 32'd1;
          emit_interval({16'd0, hi_byte, b});
        end
        PH_F3_HI: begin
          byte_pos = byte_pos + 32'd1;
          hi_byte  = b;
          ph       = PH_F3_LO;
        end
        PH_SKIP: begin
          byte_pos = byte_pos + 32'd1;
          if (nop_left > 0)
            nop_left = nop_left - 2'd1;
          if (nop_left == 0)
            ph = PH_IDLE;
        end
        PH_OOB_TYPE: begin
          oob_type = b;
          ph       = PH_OOB_SZ_LO;
        end
        PH_OOB_SZ_LO: begin
          oob_left = {8'd0, b};
          ph       = PH_OOB_SZ_HI;
        end
        PH_OOB_SZ_HI: begin
          oob_left = {b, oob_left[7:0]};
          if (oob_type == BLK_EOF) begin
            eof_seen = 1'b1;
            ph       = PH_IDLE;
          end else if (oob_left == 0) begin
            close_block();
          end else begin
            ph = PH_OOB_DATA;
          end
        end
        PH_OOB_DATA: begin
          // only the first four payload bytes form the reported position
          if (pay_idx < POS_BYTES) begin
            pay_pos = pay_pos | ({24'd0, b} << (8 * pay_idx));
            pay_idx = pay_idx + 3'd1;
          end
          if (oob_left > 0)
            oob_left = oob_left - 16'd1;
          if (oob_left == 0)
            close_block();
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (eob) begin
      r           = totals_record(KIND_SUMMARY);
      r.truncated = !eof_seen && ph != PH_IDLE;
      awaited_records.push_back(r);
      clear_stream();
    end
    if (awaited_records.size() > due_before) begin
      r             = awaited_records.pop_back();
      r.last_of_run = 1'b1;
      awaited_records.push_back(r);
    end
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      if (error_n < MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
      error_n++;
    end
  endtask

  task automatic check_record();
    result_t want;
    if (awaited_records.size() == 0) begin
      if (error_n < MAX_REPORTS)
        $display("%0t: unexpected result, expected none, got kind %0d", $time, out_kind);
      error_n++;
    end else begin
      want = awaited_records.pop_front();
      compare_field("kind", 32'(want.kind), 32'(out_kind));
      compare_field("flux_ticks", want.flux_ticks, out_flux_ticks);
      compare_field("position_counted", want.position_counted, out_position_counted);
      compare_field("position_reported", want.position_reported, out_position_reported);
      compare_field("position_ok", 32'(want.position_ok), 32'(out_position_ok));
      compare_field("flux_total", want.flux_total, out_flux_total);
      compare_field("block_total", want.block_total, out_block_total);
      compare_field("index_total", want.index_total, out_index_total);
      compare_field("overflow_total", want.overflow_total, out_overflow_total);
      compare_field("all_positions_ok", 32'(want.all_positions_ok),
                    32'(out_all_positions_ok));
      compare_field("truncated", 32'(want.truncated), 32'(out_truncated));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      flux_cap = FLUX_LIMIT_RESET;
      awaited_records.delete();
    end else begin
      if (cfg_wr_en)
        flux_cap = cfg_wr_data;
      // results lag the request through the input register and the result queue, so check before predicting
      if (out_valid && out_ready)
        check_record();
      if (in_valid && in_ready)
        decode_byte(in_stream_byte, in_end_of_buffer);
    end
    records_due <= awaited_records.size();
    mismatches  <= error_n;
  end

endmodule

FILE: verif/tb_top.sv
// testbench top for the flux stream decoder: stream stimulus, limit phases and verdict
module tb_top
  import fsdc_pkg::*;
();

  localparam int HOLD_OFF        = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int BYTES_PER_PHASE = 158;
  localparam int N_PHASES        = 6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_stream_byte;
  logic        in_end_of_buffer;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_flux_ticks;
  logic [31:0] out_position_counted;
  logic [31:0] out_position_reported;
  logic        out_position_ok;
  logic [31:0] out_flux_total;
  logic [31:0] out_block_total;
  logic [31:0] out_index_total;
  logic [31:0] out_overflow_total;
  logic        out_all_positions_ok;
  logic        out_truncated;
  logic        out_last_of_run;
  logic        cfg_wr_en;
  logic [19:0] cfg_wr_data;
  int          mismatches;
  int          records_due;

  logic [7:0]  stream_q[$];
  logic [31:0] live_pos;
  int          junk_n;
  int          sent_n = 0;
  int          stall_left = 0;
  int          big_left = 2;
  logic        idle_on = 1'b1;

  always #5 clk = ~clk;

  flux_stream_decoder_checker uut (.*);

  flux_result_checker result_chk (.*);

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // stream building: bytes outside blocks advance the position
  function automatic void put_live(input logic [7:0] b);
    stream_q.push_back(b);
    live_pos = live_pos + 32'd1;
  endfunction

  function automatic void put_flux2(input logic [2:0] hi, input logic [7:0] lo);
    put_live({5'd0, hi});
    put_live(lo);
  endfunction

  function automatic void put_flux3(input logic [7:0] hi, input logic [7:0] lo);
    put_live(OP_FLUX3);
    put_live(hi);
    put_live(lo);
  endfunction

  function automatic void put_nop(input int len);
    put_live(OP_NOP1 + 8'(len - 1));
    repeat (len - 1) put_live(8'($urandom));
  endfunction

  function automatic void put_block(input logic [7:0] btype, input logic [15:0] size,
                                    input logic pos_good);
    logic [31:0] pos;
    int          i;
    pos = pos_good ? live_pos : 32'($urandom);
    stream_q.push_back(OP_OOB);
    stream_q.push_back(btype);
    stream_q.push_back(size[7:0]);
    stream_q.push_back(size[15:8]);
    for (i = 0; i < size; i++)
      stream_q.push_back(i < POS_BYTES ? pos[8*i +: 8] : 8'($urandom));
  endfunction

  function automatic void put_eof(input int junk);
    stream_q.push_back(OP_OOB);
    stream_q.push_back(BLK_EOF);
    stream_q.push_back(8'($urandom));
    stream_q.push_back(8'($urandom));
    // ignored by the decoder until the buffer ends
    repeat (junk) begin
      stream_q.push_back(8'($urandom));
      junk_n++;
    end
  endfunction

  function automatic void start_stream();
    stream_q.delete();
    live_pos = '0;
    junk_n   = 0;
  endfunction

  function automatic void make_random_stream();
    int          n_ops;
    int          k;
    int          r;
    int          sz;
    int          cut;
    logic [7:0]  btype;
    logic        done;
    start_stream();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 24)) put_live(8'($urandom));
      return;
    end
    n_ops = $urandom_range(1, 16);
    done  = 1'b0;
    k     = 0;
    while (k < n_ops && !done) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        put_live(8'($urandom_range(OP_FLUX1_MIN, 255)));
      end else if (r < 44) begin
        put_flux2(3'($urandom), 8'($urandom));
      end else if (r < 54) begin
        put_flux3(8'($urandom), 8'($urandom));
      end else if (r < 62) begin
        repeat ($urandom_range(1, 3)) put_live(OP_OVERFLOW);
      end else if (r < 69) begin
        put_nop($urandom_range(1, 3));
      end else if (r < 85) begin
        r = $urandom_range(0, 99);
        if (big_left > 0 && r < 3) begin
          sz = $urandom_range(256, 262);
          big_left--;
        end else if (r < 14) begin
          sz = $urandom_range(0, 3);
        end else if (r < 90) begin
          sz = $urandom_range(4, 8);
        end else begin
          sz = $urandom_range(9, 24);
        end
        put_block(8'($urandom_range(BLK_INFO, BLK_END)), 16'(sz),
                  $urandom_range(0, 99) < 85);
      end else if (r < 92) begin
        do btype = 8'($urandom); while (btype == BLK_EOF);
        put_block(btype, 16'($urandom_range(0, 6)), 1'b1);
      end else if (r < 95) begin
        put_eof($urandom_range(0, 3));
        done = 1'b1;
      end else begin
        put_live(8'($urandom));
      end
      k++;
    end
    // end the buffer inside an opcode or block now and then
    if (stream_q.size() > 1 && $urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, stream_q.size() > 3 ? 3 : stream_q.size() - 1);
      repeat (cut) void'(stream_q.pop_back());
      junk_n = (junk_n > cut) ? junk_n - cut : 0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_stream_byte   <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
    sent_n += stream_q.size() - junk_n;
  endtask

  // records_due is registered, so look in the cycle after the last request
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [19:0] value);
    wait_drained();
    repeat (HOLD_OFF) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int ph_i;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_stream_byte   <= '0;
    in_end_of_buffer <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every opcode except NOP2, then an index block whose last byte ends the buffer
    start_stream();
    put_live(OP_FLUX1_MIN);
    put_live(8'hFF);
    put_flux2(3'd0, 8'h00);
    put_flux2(3'd7, 8'hFF);
    put_live(OP_OVERFLOW);
    put_flux3(8'hFF, 8'h01);
    put_nop(1);
    put_nop(3);
    put_block(BLK_INDEX, 16'd4, 1'b1);
    send_stream();

    // stop block followed by one ignored byte
    start_stream();
    put_eof(1);
    send_stream();

    // buffer ends in the middle of a three-byte interval
    start_stream();
    put_live(OP_FLUX3);
    send_stream();

    for (ph_i = 0; ph_i < N_PHASES; ph_i++) begin
      case (ph_i)
        1:       set_limit(20'd1);
        2:       set_limit(20'hFFFFF);
        3:       set_limit(20'd2);
        4:       set_limit(20'($urandom_range(3, 12)));
        5:       set_limit(FLUX_LIMIT_RESET);
        default: ;
      endcase
      idle_on = (ph_i != 3);
      while (sent_n < (ph_i + 1) * BYTES_PER_PHASE) begin
        make_random_stream();
        send_stream();
        if ($urandom_range(0, 7) == 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (HOLD_OFF) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fsdc_pkg.sv
hw/rtl/fsdc_parser.sv
hw/rtl/fsdc_result_fifo.sv
hw/rtl/flux_stream_decoder_checker.sv
verif/flux_result_checker.sv
verif/tb_top.sv
